@@ rtl/core/bwr_pkg.sv @@
// ----------------------------------------------------------------------------
// bwr_pkg: shared constants and types for ECG baseline wander removal
// Sizes of the sample path, the moving average and the sorted median store.
// ----------------------------------------------------------------------------
`default_nettype none

package bwr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int OUT_BITS    = SAMPLE_BITS + 1;
  localparam int MEAN_LEN    = 224;
  localparam int MEDIAN_LEN  = 135;

  // Input command codes.
  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Moving average ring, running sum and divisor widths.
  localparam int MEAN_AW  = $clog2(MEAN_LEN);
  localparam int SUM_BITS = SAMPLE_BITS + $clog2(MEAN_LEN);
  localparam int DIV_BITS = $clog2(MEAN_LEN + 1);

  // Median store address and fill count widths.
  localparam int MED_AW = (MEDIAN_LEN > 1) ? $clog2(MEDIAN_LEN) : 1;
  localparam int MED_CW = $clog2(MEDIAN_LEN + 1);

  // One word of the sorted median store: value plus its insertion tag.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] val;
    logic [MED_AW-1:0]             tag;
  } med_word_t;

endpackage

`default_nettype wire

@@ rtl/core/bwr_if.sv @@
// ----------------------------------------------------------------------------
// bwr channel interfaces
// Valid/ready channels for input samples and filtered results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bwr_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    cmd;
  logic signed [bwr_pkg::SAMPLE_BITS-1:0]  sample;
  modport source (output valid, output cmd, output sample, input ready);
  modport sink   (input valid, input cmd, input sample, output ready);
endinterface

interface bwr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bwr_pkg::OUT_BITS-1:0]  filtered;
  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ecg_baseline_wander_removal_top.sv @@
// ----------------------------------------------------------------------------
// ecg_baseline_wander_removal_top: moving average then running median
// Subtracts the lower median of recent moving averages from each sample.
// ----------------------------------------------------------------------------
//  channel  | dir | words carried
//  samples  | in  | cmd (1 = clear), sample (signed 16)
//  results  | out | filtered (signed 17), one word per input word
//
//  A filter word passes through acceptance, the ring update, the 24-step divider,
//  a removal pass over the sorted median memory once it is full, an insertion
//  pass over it, then the median read and the result.
//  Reset is synchronous and empties both windows; no clearing pass is needed.
//  One word is in flight at a time; the result register waits on results.ready.
`default_nettype none

module ecg_baseline_wander_removal_top (
  input  wire logic  clk,
  input  wire logic  rst,
  bwr_in_if.sink     samples,
  bwr_out_if.source  results
);
  import bwr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RING, S_DIV, S_RMV, S_INS, S_INS0, S_MED, S_DONE
  } state_t;

  state_t state;

  // Moving average state.
  logic signed [SAMPLE_BITS-1:0] ring_mem [MEAN_LEN];
  logic signed [SAMPLE_BITS-1:0] ring_rd;
  logic [MEAN_AW-1:0]            ptr;
  logic                          full;
  logic signed [SUM_BITS-1:0]    sum;

  // Sorted median store.
  med_word_t         sort_mem [MEDIAN_LEN];
  med_word_t         s_rd;
  logic [MED_CW-1:0] count;
  logic [MED_AW-1:0] mptr;
  logic [MED_AW-1:0] idx;
  logic [MED_AW-1:0] rd_idx;
  logic              rd_valid;
  logic              issue;
  logic              found;

  // Item registers.
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [SAMPLE_BITS-1:0] avg;
  logic                          neg;
  logic                          clr;

  // Combinational helpers.
  logic signed [SAMPLE_BITS-1:0] ring_old;
  logic signed [SUM_BITS-1:0]    sum_next;
  logic [MEAN_AW-1:0]            ptr_next;
  logic                          full_next;
  logic [SUM_BITS-1:0]           dividend;
  logic [DIV_BITS-1:0]           divisor;
  logic                          div_done;
  logic [SUM_BITS-1:0]           quotient;
  logic signed [SAMPLE_BITS-1:0] avg_next;
  logic [MED_CW-1:0]             count_next;
  logic [MED_AW-1:0]             rank;
  logic [MED_AW-1:0]             sr_addr;
  logic                          sw_en;
  logic [MED_AW-1:0]             sw_addr;
  med_word_t                     sw_data;
  med_word_t                     new_word;
  logic                          gt;
  logic                          rmv_last;

  assign samples.ready = (state == S_IDLE);

  // Running sum update and divisor for this sample.
  always_comb begin
    ring_old  = full ? ring_rd : '0;
    sum_next  = sum - SUM_BITS'(ring_old) + SUM_BITS'(sample_r);
    full_next = full || (ptr == MEAN_AW'(MEAN_LEN - 1));
    ptr_next  = (ptr == MEAN_AW'(MEAN_LEN - 1)) ? '0 : ptr + 1'b1;
    dividend  = sum_next[SUM_BITS-1] ? -sum_next : sum_next;
    divisor   = full_next ? DIV_BITS'(MEAN_LEN) : DIV_BITS'(ptr_next);
    avg_next  = neg ? -quotient[SAMPLE_BITS-1:0] : quotient[SAMPLE_BITS-1:0];
  end

  bwr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_RING),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Ring memory: write the new sample over the slot whose old value was read.
  always_ff @(posedge clk) begin
    if (state == S_RING) begin
      ring_mem[ptr] <= sample_r;
    end
    ring_rd <= ring_mem[ptr];
  end

  // Sorted store addressing and shift writes.
  always_comb begin
    new_word.val = avg;
    new_word.tag = mptr;
    gt         = (s_rd.val > avg);
    rmv_last   = rd_valid && (rd_idx == MED_AW'(MEDIAN_LEN - 1));
    count_next = (count == MED_CW'(MEDIAN_LEN)) ? count : count + 1'b1;
    rank       = MED_AW'((count_next - 1'b1) >> 1);
    sr_addr    = (state == S_MED) ? rank : idx;
    sw_en      = 1'b0;
    sw_addr    = '0;
    sw_data    = new_word;
    case (state)
      S_RMV: begin
        sw_en   = rd_valid && found;
        sw_addr = rd_idx - 1'b1;
        sw_data = s_rd;
      end
      S_INS: begin
        sw_en   = rd_valid;
        sw_addr = rd_idx + 1'b1;
        sw_data = gt ? s_rd : new_word;
      end
      S_INS0: begin
        sw_en = 1'b1;
      end
      default: ;
    endcase
  end

  // The median read is held while the result waits to be sent.
  always_ff @(posedge clk) begin
    if (sw_en) begin
      sort_mem[sw_addr] <= sw_data;
    end
    if (state != S_DONE) begin
      s_rd <= sort_mem[sr_addr];
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ptr           <= '0;
      full          <= 1'b0;
      sum           <= '0;
      count         <= '0;
      mptr          <= '0;
      rd_valid      <= 1'b0;
      issue         <= 1'b0;
      found         <= 1'b0;
      clr           <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (results.valid && results.ready && state != S_DONE) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (samples.valid) begin
            sample_r <= samples.sample;
            clr      <= (samples.cmd == CMD_CLEAR);
            if (samples.cmd == CMD_CLEAR) begin
              ptr   <= '0;
              full  <= 1'b0;
              sum   <= '0;
              count <= '0;
              mptr  <= '0;
              state <= S_DONE;
            end else begin
              state <= S_RING;
            end
          end
        end
        S_RING: begin
          sum   <= sum_next;
          ptr   <= ptr_next;
          full  <= full_next;
          neg   <= sum_next[SUM_BITS-1];
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            avg      <= avg_next;
            rd_valid <= 1'b0;
            found    <= 1'b0;
            if (count == MED_CW'(MEDIAN_LEN)) begin
              idx   <= '0;
              issue <= 1'b1;
              state <= S_RMV;
            end else if (count == '0) begin
              state <= S_INS0;
            end else begin
              idx   <= MED_AW'(count - 1'b1);
              issue <= 1'b1;
              state <= S_INS;
            end
          end
        end
        S_RMV: begin
          // Stream every entry, closing the gap left by the oldest one.
          if (rd_valid && s_rd.tag == mptr) begin
            found <= 1'b1;
          end
          if (rmv_last) begin
            rd_valid <= 1'b0;
            if (MEDIAN_LEN == 1) begin
              issue <= 1'b0;
              state <= S_INS0;
            end else begin
              idx   <= MED_AW'(MEDIAN_LEN - 2);
              issue <= 1'b1;
              state <= S_INS;
            end
          end else begin
            rd_valid <= issue;
            rd_idx   <= idx;
            if (issue) begin
              idx <= idx + 1'b1;
              if (idx == MED_AW'(MEDIAN_LEN - 1)) begin
                issue <= 1'b0;
              end
            end
          end
        end
        S_INS: begin
          // Walk down from the top, moving larger entries up by one.
          if (rd_valid && !(gt && rd_idx != '0)) begin
            rd_valid <= 1'b0;
            issue    <= 1'b0;
            state    <= gt ? S_INS0 : S_MED;
          end else begin
            rd_valid <= issue;
            rd_idx   <= idx;
            if (issue) begin
              idx <= idx - 1'b1;
              if (idx == '0) begin
                issue <= 1'b0;
              end
            end
          end
        end
        S_INS0: begin
          state <= S_MED;
        end
        S_MED: begin
          count <= count_next;
          mptr  <= (mptr == MED_AW'(MEDIAN_LEN - 1)) ? '0 : mptr + 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!results.valid || results.ready) begin
            results.filtered <= clr ? '0
                              : OUT_BITS'(sample_r) - OUT_BITS'(s_rd.val);
            results.valid    <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The median fill count never passes the window length.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= MED_CW'(MEDIAN_LEN))
    else $error("median count beyond window length");

  // The divider only finishes while the sequencer waits for it.
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside divide state");

  // The oldest entry must be found by the end of the removal pass.
  a_rmv_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_RMV && rmv_last) |-> (found || s_rd.tag == mptr))
    else $error("oldest median entry not found");

  // An accepted filter word starts the ring update next.
  a_accept_ring: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready && samples.cmd == CMD_FILTER) |=> state == S_RING)
    else $error("accepted word did not start ring update");

endmodule

`default_nettype wire

@@ rtl/core/bwr_div.sv @@
// ----------------------------------------------------------------------------
// bwr_div: restoring unsigned divider
// One quotient bit per cycle; done pulses once the last quotient bit is in.
// ----------------------------------------------------------------------------
`default_nettype none

module bwr_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [bwr_pkg::SUM_BITS-1:0] dividend,
  input  wire logic [bwr_pkg::DIV_BITS-1:0] divisor,
  output logic                              done,
  output logic [bwr_pkg::SUM_BITS-1:0]      quotient
);
  import bwr_pkg::*;

  localparam int CNT_W = $clog2(SUM_BITS);

  logic [DIV_BITS-1:0] rem;
  logic [DIV_BITS-1:0] dsor;
  logic [CNT_W-1:0]    cnt;
  logic                run;
  logic [DIV_BITS:0]   shifted;
  logic                ge;
  logic [DIV_BITS:0]   diff;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem, quotient[SUM_BITS-1]};
    diff    = shifted - {1'b0, dsor};
    ge      = (shifted >= {1'b0, dsor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= '0;
        dsor     <= divisor;
        quotient <= dividend;
        cnt      <= '0;
        run      <= 1'b1;
      end else if (run) begin
        rem      <= ge ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
        quotient <= {quotient[SUM_BITS-2:0], ge};
        cnt      <= cnt + 1'b1;
        if (cnt == CNT_W'(SUM_BITS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire
